@@ sv/ffx_pkg.sv @@
// ---------------------------------------------------------------------------
// ffx_pkg
// Shared types and constants for the flat-field transmission block.
// ---------------------------------------------------------------------------
`default_nettype none

package ffx_pkg;

  // Field widths fixed by the interface.
  localparam int DET_W      = 8;
  localparam int BIN_W      = 10;
  localparam int COUNT_W    = 16;
  localparam int Q_W        = 20;
  localparam int WSUM_W     = 28;
  localparam int AIR_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int NCOUNT_W   = 5;

  // Width used to compare field values against the size parameters.
  localparam int LIM_W = 13;

  // Saturation values.
  localparam logic [Q_W-1:0]    QMAX     = '1;
  localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
  localparam logic [AIR_W-1:0]  AIR_MAX  = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIN_A_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_A_LAST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_B_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_B_LAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USE_B       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_COUNT   = 3'd5;

  // Last step indexes of the shared divider and the square root unit.
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] TDIV_LAST = 6'd19;
  localparam logic [STEP_W-1:0] EDIV_LAST = 6'd39;
  localparam logic [STEP_W-1:0] SQRT_LAST = 6'd19;

  // Configuration register contents.
  typedef struct packed {
    logic [BIN_W-1:0]    win_a_first;
    logic [BIN_W-1:0]    win_a_last;
    logic [BIN_W-1:0]    win_b_first;
    logic [BIN_W-1:0]    win_b_last;
    logic                use_b;
    logic [NCOUNT_W-1:0] air_count;
  } cfg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_AIR_WRITE,
    OP_SQ,
    OP_CUBE_LO,
    OP_CUBE_HI,
    OP_CUBE_SUM,
    OP_CS_LO,
    OP_CS_HI,
    OP_CS_SUM,
    OP_P_LO,
    OP_P_HI,
    OP_P_SUM,
    OP_TDIV_INIT,
    OP_EDIV_INIT,
    OP_DIV_STEP,
    OP_T_DONE,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_PUSH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic take;
  } cmd_t;

  typedef struct packed {
    logic object_line;
    logic zero_air;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/ffx_cfg.sv @@
// ---------------------------------------------------------------------------
// ffx_cfg
// Configuration register file: energy windows, total mode and air count.
// ---------------------------------------------------------------------------
`default_nettype none

module ffx_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffx_pkg::CFG_DATA_W-1:0] cfg_data,
  output ffx_pkg::cfg_t                  cfg
);
  import ffx_pkg::*;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_a_first <= 10'd10;
      cfg.win_a_last  <= 10'd50;
      cfg.win_b_first <= 10'd10;
      cfg.win_b_last  <= 10'd90;
      cfg.use_b       <= 1'b0;
      cfg.air_count   <= 5'd14;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIN_A_FIRST: cfg.win_a_first <= cfg_data;
        REG_WIN_A_LAST:  cfg.win_a_last  <= cfg_data;
        REG_WIN_B_FIRST: cfg.win_b_first <= cfg_data;
        REG_WIN_B_LAST:  cfg.win_b_last  <= cfg_data;
        REG_USE_B:       cfg.use_b       <= cfg_data[0];
        REG_AIR_COUNT:   cfg.air_count   <= cfg_data[NCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/ffx_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffx_ctrl
// Sequencer: accepts bins, then steps the datapath through the air update
// or through the multiply, divide and square root sequence of an object line.
// ---------------------------------------------------------------------------
`default_nettype none

module ffx_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  ffx_pkg::stat_t stat,
  output ffx_pkg::cmd_t  cmd
);
  import ffx_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_AIR_WR,
    S_CHECK,
    S_SQ,
    S_CUBE_LO,
    S_CUBE_HI,
    S_CUBE_SUM,
    S_CS_LO,
    S_CS_HI,
    S_CS_SUM,
    S_P_LO,
    S_P_HI,
    S_P_SUM,
    S_TDIV_INIT,
    S_TDIV,
    S_T_DONE,
    S_EDIV_INIT,
    S_EDIV,
    S_SQRT_INIT,
    S_SQRT,
    S_PUSH
  } state_t;

  state_t             state;
  logic [STEP_W-1:0]  step;

  // Bins are taken only while no spectrum is being closed.
  assign in_ready = (state == S_IDLE);

  // State and iteration counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_last) state <= S_LOAD;
        end
        S_LOAD:     state <= stat.object_line ? S_CHECK : S_AIR_WR;
        S_AIR_WR:   state <= S_IDLE;
        S_CHECK:    state <= stat.zero_air ? S_PUSH : S_SQ;
        S_SQ:       state <= S_CUBE_LO;
        S_CUBE_LO:  state <= S_CUBE_HI;
        S_CUBE_HI:  state <= S_CUBE_SUM;
        S_CUBE_SUM: state <= S_CS_LO;
        S_CS_LO:    state <= S_CS_HI;
        S_CS_HI:    state <= S_CS_SUM;
        S_CS_SUM:   state <= S_P_LO;
        S_P_LO:     state <= S_P_HI;
        S_P_HI:     state <= S_P_SUM;
        S_P_SUM:    state <= S_TDIV_INIT;
        S_TDIV_INIT: begin
          state <= S_TDIV;
          step  <= TDIV_LAST;
        end
        S_TDIV: begin
          if (step == '0) state <= S_T_DONE;
          else step <= step - 1'b1;
        end
        S_T_DONE:   state <= S_EDIV_INIT;
        S_EDIV_INIT: begin
          state <= S_EDIV;
          step  <= EDIV_LAST;
        end
        S_EDIV: begin
          if (step == '0) state <= S_SQRT_INIT;
          else step <= step - 1'b1;
        end
        S_SQRT_INIT: begin
          state <= S_SQRT;
          step  <= SQRT_LAST;
        end
        S_SQRT: begin
          if (step == '0) state <= S_PUSH;
          else step <= step - 1'b1;
        end
        S_PUSH: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operation decode for the datapath.
  always_comb begin
    cmd.take = in_valid && (state == S_IDLE);
    case (state)
      S_LOAD:      cmd.op = OP_LOAD;
      S_AIR_WR:    cmd.op = OP_AIR_WRITE;
      S_SQ:        cmd.op = OP_SQ;
      S_CUBE_LO:   cmd.op = OP_CUBE_LO;
      S_CUBE_HI:   cmd.op = OP_CUBE_HI;
      S_CUBE_SUM:  cmd.op = OP_CUBE_SUM;
      S_CS_LO:     cmd.op = OP_CS_LO;
      S_CS_HI:     cmd.op = OP_CS_HI;
      S_CS_SUM:    cmd.op = OP_CS_SUM;
      S_P_LO:      cmd.op = OP_P_LO;
      S_P_HI:      cmd.op = OP_P_HI;
      S_P_SUM:     cmd.op = OP_P_SUM;
      S_TDIV_INIT: cmd.op = OP_TDIV_INIT;
      S_TDIV:      cmd.op = OP_DIV_STEP;
      S_T_DONE:    cmd.op = OP_T_DONE;
      S_EDIV_INIT: cmd.op = OP_EDIV_INIT;
      S_EDIV:      cmd.op = OP_DIV_STEP;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT_STEP;
      S_PUSH:      cmd.op = stat.out_free ? OP_PUSH : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/ffx_dpath.sv @@
// ---------------------------------------------------------------------------
// ffx_dpath
// Datapath: window accumulation, per-detector air store, a shared 32x32
// multiplier, a bit-serial restoring divider, a bit-pair square root unit
// and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ffx_dpath #(
  parameter int NUM_DETECTORS = 256,
  parameter int NUM_BINS      = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ffx_pkg::cmd_t                cmd,
  input  ffx_pkg::cfg_t                cfg,
  input  logic                         command,
  input  logic [ffx_pkg::DET_W-1:0]    detector,
  input  logic                         source,
  input  logic [ffx_pkg::BIN_W-1:0]    bin_index,
  input  logic [ffx_pkg::COUNT_W-1:0]  bin_count,
  input  logic                         last_bin,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ffx_pkg::DET_W-1:0]    out_detector,
  output logic [ffx_pkg::Q_W-1:0]      transmission,
  output logic [ffx_pkg::Q_W-1:0]      transmission_error,
  output logic                         zero_air,
  output ffx_pkg::stat_t               stat
);
  import ffx_pkg::*;

  // Only detectors that the detector field can name need storage.
  localparam int AIR_DEPTH = (NUM_DETECTORS < (1 << DET_W)) ? NUM_DETECTORS : (1 << DET_W);
  localparam int AIR_AW    = (AIR_DEPTH > 1) ? $clog2(AIR_DEPTH) : 1;

  // Window accumulation and latched spectrum data.
  logic [WSUM_W-1:0]   wsum;
  logic [WSUM_W-1:0]   wsum_next;
  logic [WSUM_W:0]     wsum_add;
  logic                hit_a, hit_b, hit, bin_ok, det_ok;
  logic [WSUM_W-1:0]   lat_c;
  logic [DET_W-1:0]    lat_det;
  logic                lat_ok;
  logic                lat_object;

  // Air store with one valid bit per entry.
  logic [AIR_W-1:0]     air_mem [AIR_DEPTH];
  logic [AIR_DEPTH-1:0] air_valid;
  logic [AIR_W-1:0]     mem_q;
  logic                 mem_vq;
  logic [AIR_W:0]       air_add;
  logic [AIR_W-1:0]     air_new;
  logic                 air_we;

  // Arithmetic operands and intermediates.
  logic [AIR_W-1:0]    a_reg;
  logic [NCOUNT_W-1:0] n_eff;
  logic [32:0]         cn;
  logic [9:0]          nn;
  logic [33:0]         s_val;
  logic [63:0]         sq;
  logic [63:0]         p_lo;
  logic [63:0]         p_hi;
  logic [95:0]         dv;
  logic [63:0]         cs;
  logic [71:0]         pv;
  logic [31:0]         mul_x, mul_y;
  logic [63:0]         mul_p;

  // Divider registers.
  logic [95:0]         dd;
  logic [95:0]         rr;
  logic [39:0]         ss;
  logic [39:0]         qq;
  logic                dsat;
  logic [96:0]         div_rt;
  logic [96:0]         div_diff;
  logic                div_ge;
  logic [95:0]         div_rem_next;

  // Square root registers.
  logic [39:0]         rad;
  logic [21:0]         rem;
  logic [19:0]         root;
  logic [23:0]         rem_t;
  logic [23:0]         trial;
  logic [23:0]         sq_diff;
  logic                sq_ge;

  // Finished values.
  logic [Q_W-1:0]      t_val;
  logic                e_sat;
  logic                a_zero;

  // Window hit test and saturating accumulation of the incoming bin.
  always_comb begin
    hit_a    = (bin_index >= cfg.win_a_first) && (bin_index <= cfg.win_a_last);
    hit_b    = cfg.use_b && (bin_index >= cfg.win_b_first) && (bin_index <= cfg.win_b_last);
    bin_ok   = LIM_W'(bin_index) < LIM_W'(NUM_BINS);
    det_ok   = LIM_W'(detector) < LIM_W'(NUM_DETECTORS);
    hit      = (source ? hit_b : hit_a) && bin_ok;
    wsum_add = {1'b0, wsum} + (hit ? (WSUM_W + 1)'(bin_count) : '0);
    wsum_next = wsum_add[WSUM_W] ? WSUM_MAX : wsum_add[WSUM_W-1:0];
  end

  // Saturating air update.
  always_comb begin
    air_add = {1'b0, a_reg} + (AIR_W + 1)'(lat_c);
    air_new = air_add[AIR_W] ? AIR_MAX : air_add[AIR_W-1:0];
    air_we  = (cmd.op == OP_AIR_WRITE) && lat_ok;
    n_eff   = (cfg.air_count == '0) ? NCOUNT_W'(1) : cfg.air_count;
    a_zero  = (a_reg == '0);
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.op)
      OP_LOAD: begin
        mul_x = 32'(lat_c);
        mul_y = 32'(n_eff);
      end
      OP_SQ: begin
        mul_x = a_reg;
        mul_y = a_reg;
      end
      OP_CUBE_LO: begin
        mul_x = sq[31:0];
        mul_y = a_reg;
      end
      OP_CUBE_HI: begin
        mul_x = sq[63:32];
        mul_y = a_reg;
      end
      OP_CS_LO: begin
        mul_x = 32'(lat_c);
        mul_y = s_val[31:0];
      end
      OP_CS_HI: begin
        mul_x = 32'(lat_c);
        mul_y = 32'(s_val[33:32]);
      end
      OP_P_LO: begin
        mul_x = cs[31:0];
        mul_y = 32'(nn);
      end
      OP_P_HI: begin
        mul_x = cs[63:32];
        mul_y = 32'(nn);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    mul_p = mul_x * mul_y;
  end

  // One restoring division step: shift in the next dividend bit.
  always_comb begin
    div_rt       = {rr, ss[39]};
    div_diff     = div_rt - {1'b0, dd};
    div_ge       = div_rt >= {1'b0, dd};
    div_rem_next = div_ge ? div_diff[95:0] : div_rt[95:0];
  end

  // One square root step: bring down the next bit pair.
  always_comb begin
    rem_t   = {rem, rad[39:38]};
    trial   = {2'b00, root, 2'b01};
    sq_diff = rem_t - trial;
    sq_ge   = rem_t >= trial;
  end

  // Control state: window sum, valid bits and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      wsum      <= '0;
      air_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) wsum <= last_bin ? '0 : wsum_next;
      if (air_we) air_valid[lat_det[AIR_AW-1:0]] <= 1'b1;
      if (cmd.op == OP_PUSH) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Air store: registered read at the incoming detector, write on update.
  always_ff @(posedge clk) begin
    mem_q  <= air_mem[detector[AIR_AW-1:0]];
    mem_vq <= air_valid[detector[AIR_AW-1:0]];
    if (air_we) air_mem[lat_det[AIR_AW-1:0]] <= air_new;
  end

  // Payload registers of the closing spectrum and the arithmetic sequence.
  always_ff @(posedge clk) begin
    if (cmd.take && last_bin) begin
      lat_c      <= wsum_next;
      lat_det    <= detector;
      lat_ok     <= det_ok;
      lat_object <= command;
    end
    case (cmd.op)
      OP_LOAD: begin
        a_reg <= (mem_vq && lat_ok) ? mem_q : '0;
        cn    <= mul_p[32:0];
        nn    <= 10'(n_eff) * 10'(n_eff);
      end
      OP_SQ: begin
        sq    <= mul_p;
        s_val <= 34'(a_reg) + 34'(cn);
      end
      OP_CUBE_LO:  p_lo <= mul_p;
      OP_CUBE_HI:  p_hi <= mul_p;
      OP_CUBE_SUM: dv   <= 96'(p_lo) + {p_hi, 32'b0};
      OP_CS_LO:    p_lo <= mul_p;
      OP_CS_HI:    p_hi <= mul_p;
      OP_CS_SUM:   cs   <= p_lo + {p_hi[31:0], 32'b0};
      OP_P_LO:     p_lo <= mul_p;
      OP_P_HI:     p_hi <= mul_p;
      OP_P_SUM:    pv   <= 72'(p_lo) + {p_hi[39:0], 32'b0};
      OP_TDIV_INIT: begin
        // Quotient of (c*n << 16) / A; saturated when it reaches 2^20.
        dd   <= 96'(a_reg);
        rr   <= 96'(cn[32:4]);
        ss   <= {cn[3:0], 36'b0};
        qq   <= '0;
        dsat <= 32'(cn[32:4]) >= a_reg;
      end
      OP_EDIV_INIT: begin
        // Quotient of (P << 32) / A^3; saturated when it reaches 2^40.
        dd   <= dv;
        rr   <= 96'(pv[71:8]);
        ss   <= {pv[7:0], 32'b0};
        qq   <= '0;
        dsat <= 96'(pv[71:8]) >= dv;
      end
      OP_DIV_STEP: begin
        rr <= div_rem_next;
        ss <= {ss[38:0], 1'b0};
        qq <= {qq[38:0], div_ge};
      end
      OP_T_DONE: t_val <= dsat ? QMAX : qq[Q_W-1:0];
      OP_SQRT_INIT: begin
        e_sat <= dsat;
        rad   <= qq;
        rem   <= '0;
        root  <= '0;
      end
      OP_SQRT_STEP: begin
        rem  <= sq_ge ? sq_diff[21:0] : rem_t[21:0];
        root <= {root[18:0], sq_ge};
        rad  <= {rad[37:0], 2'b00};
      end
      OP_PUSH: begin
        out_detector <= lat_det;
        if (a_zero) begin
          transmission       <= QMAX;
          transmission_error <= QMAX;
          zero_air           <= 1'b1;
        end else begin
          transmission       <= t_val;
          transmission_error <= e_sat ? QMAX : root;
          zero_air           <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Status back to the controller.
  assign stat.object_line = lat_object;
  assign stat.zero_air    = a_zero;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ sv/flat_field_transmission.sv @@
// ---------------------------------------------------------------------------
// flat_field_transmission
// Flat-field correction: window sums per spectrum, air averaging per
// detector, transmission and statistical error in unsigned Q4.16.
// ---------------------------------------------------------------------------
// Usage:
//   Spectrum bins enter on the in_valid/in_ready channel, one item per cycle
//   while bins do not close a spectrum. The item with last_bin set closes it.
//   An air line then updates that detector's air sum; in_ready stays low
//   while the sum is loaded and written back. An object line runs a fixed
//   sequence on one shared 32x32 multiplier, a bit-serial divider (for
//   transmission, then for the error) and a bit-pair square root; its
//   result item is pushed to out_valid once the output register is free.
//   With a zero air sum the sequence is skipped and the result is pushed
//   right after the load and check. Bins are not taken during that time.
//   The result sits in an output register: a stalled receiver holds only the
//   next result, and the block keeps taking bins of the following spectrum.
//   Configuration writes are always taken (cfg_ready is high) and are meant
//   for idle periods. Synchronous reset clears the window sum, the output
//   valid and the per-detector valid bits, so every air sum reads as zero
//   at once; configuration registers return to their defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module flat_field_transmission #(
  parameter int NUM_DETECTORS = 256,
  parameter int NUM_BINS      = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [ffx_pkg::DET_W-1:0]      detector,
  input  logic                           source,
  input  logic [ffx_pkg::BIN_W-1:0]      bin_index,
  input  logic [ffx_pkg::COUNT_W-1:0]    bin_count,
  input  logic                           last_bin,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ffx_pkg::DET_W-1:0]      out_detector,
  output logic [ffx_pkg::Q_W-1:0]        transmission,
  output logic [ffx_pkg::Q_W-1:0]        transmission_error,
  output logic                           zero_air,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ffx_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Configuration registers.
  ffx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer.
  ffx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last_bin),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  ffx_dpath #(
    .NUM_DETECTORS (NUM_DETECTORS),
    .NUM_BINS      (NUM_BINS)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .cfg                (cfg),
    .command            (command),
    .detector           (detector),
    .source             (source),
    .bin_index          (bin_index),
    .bin_count          (bin_count),
    .last_bin           (last_bin),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_detector       (out_detector),
    .transmission       (transmission),
    .transmission_error (transmission_error),
    .zero_air           (zero_air),
    .stat               (stat)
  );

`ifndef NO_ASSERTIONS
  // A result item only appears after the sequencer loads the output register.
  a_push_before_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == OP_PUSH))
    else $error("output valid rose without a push");

  // A taken closing item stops intake: in_ready is low right after it.
  a_close_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_bin) |=> !in_ready)
    else $error("bin taken right after a closing item");

  // A zero air sum always reports saturated values.
  a_zero_air_saturates: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_air) |-> (transmission == QMAX) && (transmission_error == QMAX))
    else $error("zero air sum without saturated values");
`endif

endmodule

`default_nettype wire
